FILE: rtl/delimited_uint_list_parser_core_assert.svh
// Assertion macros for the parser RTL.
// Each macro expects signals named clock and reset in the including scope.
`ifndef DELIMITED_UINT_LIST_PARSER_CORE_ASSERT_SVH
`define DELIMITED_UINT_LIST_PARSER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DULP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("parser check failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define DULP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("parser check failed: next-cycle implication");

`endif

FILE: rtl/dulp_pkg.sv
package dulp_pkg;

   // Delimiter register file.
   localparam int DELIM_REGS     = 4;
   localparam int MAX_DELIMITERS = 4;
   localparam int CHAR_W         = 8;
   localparam int VALUE_W        = 32;
   localparam int COUNT_W        = 3;
   localparam int CSR_ADDR_W     = 5;
   localparam int CSR_DATA_W     = 32;

   // Reset values of the configuration registers.
   localparam logic [COUNT_W-1:0] DELIM_COUNT_RST = 3'd2;
   localparam logic [CHAR_W-1:0]  DELIM_A_RST     = 8'd44;
   localparam logic [CHAR_W-1:0]  DELIM_B_RST     = 8'd59;
   localparam logic [CHAR_W-1:0]  DELIM_C_RST     = 8'd0;
   localparam logic [CHAR_W-1:0]  DELIM_D_RST     = 8'd0;

   // Character codes.
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

   typedef enum logic [1:0] {
      PH_SKIP   = 2'd0,
      PH_DIGITS = 2'd1,
      PH_TRAIL  = 2'd2,
      PH_DROP   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      REG_DELIM_COUNT = 3'd0,
      REG_DELIM_A     = 3'd1,
      REG_DELIM_B     = 3'd2,
      REG_DELIM_C     = 3'd3,
      REG_DELIM_D     = 3'd4
   } csr_index_type;

   function automatic logic is_blank(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage

FILE: rtl/delimited_uint_list_parser_core.sv
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_ready   req_char_code[7:0], req_is_end
// rsp       out        rsp_valid / rsp_ready   rsp_number_value[31:0]
// csr       in/out     APB-style, pready = 1   csr_paddr[4:0], csr_pwdata, csr_prdata
//
// From acceptance to its result, a word passes the input register and then
// the result register. A new word is accepted every cycle while the result
// side keeps up; the per-word step (delimiter match, digit test and one
// multiply-by-ten add) is combinational logic on the scan state.
// Reset is synchronous and active high; it clears the scan state, both valid
// flags and the configuration registers to their defaults.
// A stalled result holds the result register and, in turn, the input register;
// req_ready drops only when both are full and the result is not being taken.

`include "delimited_uint_list_parser_core_assert.svh"

module delimited_uint_list_parser_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input character stream.
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [dulp_pkg::CHAR_W-1:0]          req_char_code,
   input  logic                                 req_is_end,
   // Parsed numbers.
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dulp_pkg::VALUE_W-1:0]         rsp_number_value,
   // Configuration port.
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [dulp_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [dulp_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [dulp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic [dulp_pkg::COUNT_W-1:0] delim_count_ff;
   logic [dulp_pkg::CHAR_W-1:0]  delim_ff [dulp_pkg::DELIM_REGS];
   logic                         csr_write;
   dulp_pkg::csr_index_type      csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   // Registers sit on word addresses, so the index is the address above the
   // byte offset.
   assign csr_index  = dulp_pkg::csr_index_type'(csr_paddr[dulp_pkg::CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_count_ff <= dulp_pkg::DELIM_COUNT_RST;
         delim_ff[0]    <= dulp_pkg::DELIM_A_RST;
         delim_ff[1]    <= dulp_pkg::DELIM_B_RST;
         delim_ff[2]    <= dulp_pkg::DELIM_C_RST;
         delim_ff[3]    <= dulp_pkg::DELIM_D_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            dulp_pkg::REG_DELIM_COUNT: begin
               delim_count_ff <= csr_pwdata[dulp_pkg::COUNT_W-1:0];
            end
            dulp_pkg::REG_DELIM_A: begin
               delim_ff[0] <= csr_pwdata[dulp_pkg::CHAR_W-1:0];
            end
            dulp_pkg::REG_DELIM_B: begin
               delim_ff[1] <= csr_pwdata[dulp_pkg::CHAR_W-1:0];
            end
            dulp_pkg::REG_DELIM_C: begin
               delim_ff[2] <= csr_pwdata[dulp_pkg::CHAR_W-1:0];
            end
            dulp_pkg::REG_DELIM_D: begin
               delim_ff[3] <= csr_pwdata[dulp_pkg::CHAR_W-1:0];
            end
            default: begin
               // Addresses past the register list are ignored.
            end
         endcase
      end
   end

   // Reads are combinational; pready is always high.
   always_comb begin
      unique case (csr_index)
         dulp_pkg::REG_DELIM_COUNT: begin
            csr_prdata = {{(dulp_pkg::CSR_DATA_W-dulp_pkg::COUNT_W){1'b0}}, delim_count_ff};
         end
         dulp_pkg::REG_DELIM_A: begin
            csr_prdata = {{(dulp_pkg::CSR_DATA_W-dulp_pkg::CHAR_W){1'b0}}, delim_ff[0]};
         end
         dulp_pkg::REG_DELIM_B: begin
            csr_prdata = {{(dulp_pkg::CSR_DATA_W-dulp_pkg::CHAR_W){1'b0}}, delim_ff[1]};
         end
         dulp_pkg::REG_DELIM_C: begin
            csr_prdata = {{(dulp_pkg::CSR_DATA_W-dulp_pkg::CHAR_W){1'b0}}, delim_ff[2]};
         end
         dulp_pkg::REG_DELIM_D: begin
            csr_prdata = {{(dulp_pkg::CSR_DATA_W-dulp_pkg::CHAR_W){1'b0}}, delim_ff[3]};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Input register. It holds one word until the scan stage takes it.
   // ------------------------------------------------------------------
   logic                         in_valid_ff;
   logic                         in_valid_in;
   logic [dulp_pkg::CHAR_W-1:0]  in_char_ff;
   logic                         in_end_ff;
   logic                         advance;
   logic                         req_take;

   // The scan stage consumes a word whenever the result register is empty or
   // is being emptied in this same cycle.
   assign advance   = in_valid_ff & (~rsp_valid | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign req_take  = req_valid & req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_char_code;
         in_end_ff  <= req_is_end;
      end
   end

   // ------------------------------------------------------------------
   // Delimiter match. A register takes part when its slot number is below
   // both the programmed count and the build limit; larger counts saturate.
   // ------------------------------------------------------------------
   logic [dulp_pkg::DELIM_REGS-1:0] delim_hit;
   logic                            is_delim;

   always_comb begin
      for (int i = 0; i < dulp_pkg::DELIM_REGS; i++) begin
         delim_hit[i] = (i < dulp_pkg::MAX_DELIMITERS)
                        && ({1'b0, delim_count_ff} > 4'(i))
                        && (delim_ff[i] == in_char_ff);
      end
   end

   assign is_delim = |delim_hit;

   // ------------------------------------------------------------------
   // Scan state machine and accumulator.
   // ------------------------------------------------------------------
   dulp_pkg::phase_type                phase_ff;
   dulp_pkg::phase_type                phase_in;
   logic [dulp_pkg::VALUE_W-1:0]       acc_ff;
   logic [dulp_pkg::VALUE_W-1:0]       acc_in;
   logic [dulp_pkg::VALUE_W+3:0]       acc_times_ten;
   logic [3:0]                         digit_value;
   logic                               token_end;
   logic                               pending;
   logic                               emit;

   // acc * 10 + digit, four bits wider so that overflow shows in the top bits.
   assign digit_value   = 4'(in_char_ff - dulp_pkg::CH_ZERO);
   assign acc_times_ten = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                          + {{dulp_pkg::VALUE_W{1'b0}}, digit_value};

   // A delimiter wins over every other test; the end marker ignores the byte.
   assign token_end = in_end_ff | is_delim;
   assign pending   = (phase_ff == dulp_pkg::PH_DIGITS) | (phase_ff == dulp_pkg::PH_TRAIL);
   assign emit      = advance & token_end & pending;

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      if (advance) begin
         priority if (token_end) begin
            phase_in = dulp_pkg::PH_SKIP;
            acc_in   = '0;
         end else begin
            unique case (phase_ff)
               dulp_pkg::PH_SKIP: begin
                  if (dulp_pkg::is_digit(in_char_ff)) begin
                     phase_in = dulp_pkg::PH_DIGITS;
                     acc_in   = {{(dulp_pkg::VALUE_W-4){1'b0}}, digit_value};
                  end else if (!dulp_pkg::is_blank(in_char_ff)) begin
                     phase_in = dulp_pkg::PH_DROP;
                  end
               end
               dulp_pkg::PH_DIGITS: begin
                  if (dulp_pkg::is_digit(in_char_ff)) begin
                     if (|acc_times_ten[dulp_pkg::VALUE_W+3:dulp_pkg::VALUE_W]) begin
                        // The value no longer fits; the whole token is dropped.
                        phase_in = dulp_pkg::PH_DROP;
                        acc_in   = '0;
                     end else begin
                        acc_in = acc_times_ten[dulp_pkg::VALUE_W-1:0];
                     end
                  end else begin
                     // Text after the leading digits is ignored.
                     phase_in = dulp_pkg::PH_TRAIL;
                  end
               end
               dulp_pkg::PH_TRAIL, dulp_pkg::PH_DROP: begin
                  // Wait for the next delimiter or the end of text.
               end
               default: begin
                  phase_in = dulp_pkg::PH_SKIP;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dulp_pkg::PH_SKIP;
         acc_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register.
   // ------------------------------------------------------------------
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [dulp_pkg::VALUE_W-1:0] rsp_value_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_value_ff <= acc_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_number_value = rsp_value_ff;

   // ------------------------------------------------------------------
   // Checks.
   // ------------------------------------------------------------------
   // The end marker always leaves the scanner clean for the next text.
   `DULP_ASSERT_NEXT(a_end_clears_scan, advance && in_end_ff,
                     phase_ff == dulp_pkg::PH_SKIP && acc_ff == '0)
   // Outside a token the accumulator never carries a stale value.
   `DULP_ASSERT_SAME(a_idle_acc_zero,
                     phase_ff == dulp_pkg::PH_SKIP || phase_ff == dulp_pkg::PH_DROP,
                     acc_ff == '0)
   // A new result appears only right after the scan stage took a word.
   `DULP_ASSERT_SAME(a_result_from_scan, $rose(rsp_valid_ff), $past(advance))

endmodule

FILE: dv/parsed_number_board_pkg.sv
package parsed_number_board_pkg;

   import dulp_pkg::*;

   // Tracks the parser state for every accepted word and holds the numbers
   // that the block still owes on its result channel.
   class parsed_number_board;

      logic [COUNT_W-1:0] delim_count;
      logic [CHAR_W-1:0]  delim_char[DELIM_REGS];
      phase_type          scan;
      logic [VALUE_W-1:0] acc;
      logic [VALUE_W-1:0] due_numbers[$];
      int unsigned        mismatches;

      function new();
         delim_count  = DELIM_COUNT_RST;
         delim_char[0] = DELIM_A_RST;
         delim_char[1] = DELIM_B_RST;
         delim_char[2] = DELIM_C_RST;
         delim_char[3] = DELIM_D_RST;
         scan         = PH_SKIP;
         acc          = '0;
         mismatches   = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_DELIM_COUNT: delim_count   = value[COUNT_W-1:0];
            REG_DELIM_A:     delim_char[0] = value[CHAR_W-1:0];
            REG_DELIM_B:     delim_char[1] = value[CHAR_W-1:0];
            REG_DELIM_C:     delim_char[2] = value[CHAR_W-1:0];
            REG_DELIM_D:     delim_char[3] = value[CHAR_W-1:0];
            default: ;
         endcase
      endfunction

      // A count above the register file saturates to all four registers.
      function int unsigned delims_in_use();
         int unsigned n;
         n = delim_count;
         if (n > MAX_DELIMITERS) n = MAX_DELIMITERS;
         if (n > DELIM_REGS) n = DELIM_REGS;
         return n;
      endfunction

      function bit hits_delim(logic [CHAR_W-1:0] c);
         for (int i = 0; i < delims_in_use(); i++) begin
            if (delim_char[i] == c) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_word(logic [CHAR_W-1:0] c, logic end_mark);
         bit                pending;
         bit                digit;
         bit                blank;
         longint unsigned   grown;
         pending = (scan == PH_DIGITS) || (scan == PH_TRAIL);
         if (end_mark || hits_delim(c)) begin
            if (pending) due_numbers.insert(due_numbers.size(), acc);
            scan = PH_SKIP;
            acc  = '0;
            return;
         end
         digit = (c >= CH_ZERO) && (c <= CH_NINE);
         blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
         case (scan)
            PH_SKIP: begin
               if (digit) begin
                  acc  = VALUE_W'(c - CH_ZERO);
                  scan = PH_DIGITS;
               end else if (!blank) begin
                  scan = PH_DROP;
               end
            end
            PH_DIGITS: begin
               if (digit) begin
                  grown = 64'(acc) * 64'd10 + 64'(c - CH_ZERO);
                  if (grown > 64'hFFFF_FFFF) begin
                     scan = PH_DROP;
                     acc  = '0;
                  end else begin
                     acc = grown[VALUE_W-1:0];
                  end
               end else begin
                  scan = PH_TRAIL;
               end
            end
            default: ;
         endcase
      endfunction

      task report(string msg);
         $display("ERROR: %s", msg);
         mismatches++;
      endtask

      task check_number(logic [VALUE_W-1:0] value);
         logic [VALUE_W-1:0] owed;
         if (due_numbers.size() == 0) begin
            report($sformatf("number %0d emitted with none owed", value));
            return;
         end
         owed = due_numbers.pop_front();
         if (value !== owed)
            report($sformatf("number_value %0d, expected %0d", value, owed));
      endtask

   endclass

endpackage

FILE: dv/tb_delimited_uint_list_parser_core.sv
module tb_delimited_uint_list_parser_core;

   import dulp_pkg::*;
   import parsed_number_board_pkg::*;

   // Words per random phase; seven phases give roughly 1800 words in all.
   localparam int unsigned PHASE_WORDS  = 260;
   // A word passes the input register and then the result register, so the extra
   // cycles after the last owed number guarantee the pipeline is empty.
   localparam int unsigned DRAIN_CYCLES = 6;
   // Far above the slowest legal run: every word waiting out sender gaps and
   // receiver stalls, plus the configuration phases.
   localparam int unsigned CYCLE_LIMIT  = 200000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [CHAR_W-1:0]     req_char_code;
   logic                  req_is_end;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [VALUE_W-1:0]    rsp_number_value;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   parsed_number_board board;
   // When set, neither side idles: a long stretch at full rate.
   bit                 steady;
   int unsigned        words_sent;
   int unsigned        cycles;

   delimited_uint_list_parser_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_is_end       (req_is_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_number_value (rsp_number_value),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog. A hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Both channels are sampled at the clock edge, before any of this edge's
   // updates land. A word is noted before a result is checked; since a word
   // passes the input register before any result it closes is registered, a
   // result never depends on a word that is accepted at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_word(req_char_code, req_is_end);
         if (rsp_valid && rsp_ready) board.check_number(rsp_number_value);
      end
   end

   // The result side stalls in about a quarter of the cycles.
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 26);
   end

   // Offers one word and returns at the edge where it is accepted. The caller
   // is always at a clock edge, so each call makes at most one assignment to
   // req_valid in the current time step.
   task automatic send_word(input logic [CHAR_W-1:0] code, input logic end_mark);
      while (!steady && $urandom_range(99) < 26) begin
         req_valid     <= 1'b0;
         req_char_code <= CHAR_W'($urandom);
         req_is_end    <= 1'($urandom);
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= code;
      req_is_end    <= end_mark;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   function automatic logic [CHAR_W-1:0] pick_blank();
      case ($urandom_range(3))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_LF;
         default: return CH_CR;
      endcase
   endfunction

   // One list element: mostly well-formed numbers with random content, some
   // with leading blanks, a bad first character, leading zeros, values at
   // and just past the 32-bit limit, or trailing text. A share of plain
   // random bytes keeps the parser honest about what it ignores. Each
   // element is closed by an active delimiter or by end of text.
   task automatic send_token();
      int unsigned     kind;
      int unsigned     n;
      longint unsigned value;
      string           digits;
      kind = $urandom_range(99);
      if (kind < 8) begin
         n = $urandom_range(1, 6);
         repeat (n) send_word(CHAR_W'($urandom), 1'b0);
      end else begin
         n = $urandom_range(0, 2);
         repeat (n) send_word(pick_blank(), 1'b0);
         // Sign characters and other punctuation make a bad start.
         if (kind < 16) send_word(CHAR_W'($urandom_range(33, 47)), 1'b0);
         case ($urandom_range(9))
            0:       value = 64'd4294967295 - $urandom_range(3);
            1:       value = 64'd4294967296 + $urandom_range(3);
            2:       value = {$urandom, $urandom};
            3, 4:    value = $urandom;
            default: value = $urandom_range(999);
         endcase
         if ($urandom_range(9) == 0) begin
            n = $urandom_range(1, 2);
            repeat (n) send_word(CH_ZERO, 1'b0);
         end
         digits = $sformatf("%0d", value);
         foreach (digits[i]) send_word(digits[i], 1'b0);
         if ($urandom_range(3) == 0) begin
            n = $urandom_range(1, 3);
            repeat (n) send_word(CHAR_W'($urandom_range(32, 126)), 1'b0);
         end
      end
      if (board.delims_in_use() == 0 || $urandom_range(7) == 0)
         send_word(CHAR_W'($urandom), 1'b1);
      else
         send_word(board.delim_char[$urandom_range(board.delims_in_use() - 1)], 1'b0);
   endtask

   task automatic parse_words(input int unsigned count);
      int unsigned goal;
      goal = words_sent + count;
      while (words_sent < goal) send_token();
   endtask

   // Stops the word stream and waits until every owed number has come back,
   // then lets the pipeline empty, since the last words may owe nothing.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.due_numbers.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One APB write: setup cycle, then access cycle. The register takes the
   // value at the edge that ends the access cycle. psel and penable are left
   // for the next write or for configure to lower.
   task automatic set_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      board.write_reg(idx, value);
   endtask

   task automatic configure(input logic [COUNT_W-1:0] count, input logic [CHAR_W-1:0] a,
                            input logic [CHAR_W-1:0] b, input logic [CHAR_W-1:0] c,
                            input logic [CHAR_W-1:0] d);
      drain();
      set_reg(REG_DELIM_COUNT, CSR_DATA_W'(count));
      set_reg(REG_DELIM_A, CSR_DATA_W'(a));
      set_reg(REG_DELIM_B, CSR_DATA_W'(b));
      set_reg(REG_DELIM_C, CSR_DATA_W'(c));
      set_reg(REG_DELIM_D, CSR_DATA_W'(d));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      // With the reset delimiters: the largest value, the first overflowing
      // value, a bad start, an empty element between two delimiters, and a
      // blank, a zero and trailing text flushed by end of text.
      string opening;
      opening       = "4294967295,4294967296;+,,\t0x";
      board         = new();
      steady        = 1'b0;
      words_sent    = 0;
      cycles        <= 0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_char_code <= '0;
      req_is_end    <= 1'b0;
      rsp_ready     <= 1'b0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[i]) send_word(opening[i], 1'b0);
      send_word(8'hFF, 1'b1);
      parse_words(PHASE_WORDS);

      // All four delimiters, a blank among them so it beats blank skipping.
      configure(3'd4, ",", ";", CH_SPACE, "|");
      parse_words(PHASE_WORDS);

      // No delimiters at all: only end of text closes an element.
      configure(3'd0, 8'hFF, 8'h00, ",", ";");
      parse_words(PHASE_WORDS);

      // Count past the register file saturates; a digit and a tab are
      // delimiters, and the character extremes are too.
      configure(3'd7, 8'h00, 8'hFF, "5", CH_TAB);
      parse_words(PHASE_WORDS);

      // One delimiter, run at full rate on both sides.
      steady = 1'b1;
      configure(3'd1, ":", ",", ";", CH_SPACE);
      parse_words(PHASE_WORDS);
      steady = 1'b0;

      // Random settings drawn from punctuation, digits and the space.
      repeat (2) begin
         configure(COUNT_W'($urandom_range(7)), CHAR_W'($urandom_range(32, 63)),
                   CHAR_W'($urandom_range(32, 63)), CHAR_W'($urandom_range(32, 63)),
                   CHAR_W'($urandom_range(32, 63)));
         parse_words(PHASE_WORDS);
      end

      drain();
      if (board.due_numbers.size() != 0)
         board.report($sformatf("%0d numbers never emitted", board.due_numbers.size()));
      if (board.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
